// ===== src/lprr_pkg.sv =====
// Shared types, codes and sizes for the length-prefixed record ring.
package lprr_pkg;

    // Ring size default and fixed header size (two 32-bit little-endian words).
    localparam int RING_BYTES_DEF = 4096;
    localparam int HEADER_BYTES   = 8;
    localparam int HDR_W          = 8 * HEADER_BYTES;

    // Commands
    localparam logic [1:0] CMD_PUSH_START = 2'd0;
    localparam logic [1:0] CMD_PUSH_BYTE  = 2'd1;
    localparam logic [1:0] CMD_POP_START  = 2'd2;
    localparam logic [1:0] CMD_POP_BYTE   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ROOM   = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_TOOBIG = 3'd3;
    localparam logic [2:0] ST_SEQ    = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] length;
        logic [31:0] flow_tag;
        logic [7:0]  data_in;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] record_length;
        logic [31:0] flow_out;
        logic [7:0]  data_out;
        logic        last;
    } t_out_beat;

endpackage

// ===== src/lprr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lprr_pkg::RING_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/length_prefixed_record_ring.sv =====
// Length-prefixed record ring: top level with sequencer, pointers and byte store.
//
// Usage: one input channel (i_in_valid / o_in_ready / i_in_data) carries
// commands: push start, push payload byte, pop start, pop payload byte.
// Every accepted beat yields exactly one result beat on the output channel
// (o_out_valid / i_out_ready / o_out_data), in order.
// Records sit in a byte ring of RING_BYTES bytes held in one RAM with a
// registered read. Each record carries an 8-byte header (total length, flow
// tag, little endian) that wraps at the ring end like the payload.
// Work per beat, set by the single RAM write/read port:
//   push payload byte: one RAM write; pop payload byte: a RAM read;
//   push start: the room check, then 8 header writes;
//   pop start: read the header bytes, then decide;
//   errors (room, empty, sequence): no RAM access.
// One beat is in work at a time; o_in_ready is high only between beats.
// A finished result sits in an output register, so the next beat is taken
// while the receiver stalls; if that beat finishes before the output frees
// up, its result waits in a hold register and input stays closed.
// Reset (synchronous, active low) empties the ring and closes any open push
// or pop; RAM contents are not cleared and need not be.
module length_prefixed_record_ring #(
    parameter int RING_BYTES = lprr_pkg::RING_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lprr_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lprr_pkg::t_out_beat o_out_data
);

    localparam int PW    = $clog2(RING_BYTES);
    localparam int FW    = (PW + 1 > 13) ? PW + 1 : 13;
    localparam int HB    = lprr_pkg::HEADER_BYTES;
    localparam int HDR_W = lprr_pkg::HDR_W;
    localparam int CW    = $clog2(HB + 1);
    localparam int HIW   = $clog2(HB);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDRW  = 3'd1;
    localparam logic [2:0] S_HDRR  = 3'd2;
    localparam logic [2:0] S_PBYTE = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    // Advance a ring pointer by one byte, wrapping exactly at the ring end.
    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
        logic [PW:0] q;
        q = {1'b0, p} + (PW+1)'(1);
        if (q == (PW+1)'(RING_BYTES)) begin
            q = '0;
        end
        return q[PW-1:0];
    endfunction

    // Sequencer and working registers
    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [PW-1:0]       r_addr, n_addr;
    logic [11:0]         r_len, n_len;
    logic [31:0]         r_flow, n_flow;
    logic [HDR_W-1:0]    r_hdr, n_hdr;
    logic                r_plast, n_plast;
    lprr_pkg::t_out_beat r_res, n_res;

    // Committed pointers and open-transfer state
    logic [PW-1:0]       r_rp, n_rp;
    logic [PW-1:0]       r_wp, n_wp;
    logic [PW-1:0]       r_pushc, n_pushc;
    logic [11:0]         r_pushrem, n_pushrem;
    logic [PW-1:0]       r_popc, n_popc;
    logic [11:0]         r_poprem, n_poprem;
    logic                r_push_open, n_push_open;
    logic                r_pop_open, n_pop_open;

    // Output register
    logic                r_ovalid, n_ovalid;
    lprr_pkg::t_out_beat r_out, n_out;

    // RAM ports
    logic                w_we;
    logic [PW-1:0]       w_waddr;
    logic [7:0]          w_wdata;
    logic [PW-1:0]       w_raddr;
    logic [7:0]          w_rdata;

    // Derived values
    logic                w_in_acc;
    logic                w_out_free;
    logic [FW-1:0]       w_free;
    logic [FW-1:0]       w_total;
    logic                w_room_ok;
    logic [HB-1:0][7:0]  w_hdr_wr;
    logic [HDR_W-1:0]    w_hdr_rd;
    logic [31:0]         w_payload;
    logic                w_fin;
    lprr_pkg::t_out_beat w_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Room check: free space must strictly exceed header plus payload.
    assign w_free    = (r_rp > r_wp) ? (FW'(r_rp) - FW'(r_wp))
                                     : (FW'(r_rp) + FW'(RING_BYTES) - FW'(r_wp));
    assign w_total   = FW'(i_in_data.length) + FW'(HB);
    assign w_room_ok = (w_free > w_total);

    // Header image for writing: total length word, then flow tag word.
    assign w_hdr_wr  = {r_flow, 32'(r_len) + 32'(HB)};

    // Header as read: the last byte arrives straight from the RAM.
    assign w_hdr_rd  = {w_rdata, r_hdr[HDR_W-1:8]};
    assign w_payload = w_hdr_rd[31:0] - 32'(HB);

    lprr_ram #(
        .WIDTH (8),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_len       = r_len;
        n_flow      = r_flow;
        n_hdr       = r_hdr;
        n_plast     = r_plast;
        n_res       = r_res;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_pushc     = r_pushc;
        n_pushrem   = r_pushrem;
        n_popc      = r_popc;
        n_poprem    = r_poprem;
        n_push_open = r_push_open;
        n_pop_open  = r_pop_open;
        n_ovalid    = r_ovalid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pushc;
        w_wdata     = i_in_data.data_in;
        w_raddr     = r_popc;
        w_fin       = 1'b0;
        w_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_len  = i_in_data.length;
                    n_flow = i_in_data.flow_tag;
                    case (i_in_data.command)
                        lprr_pkg::CMD_PUSH_START: begin
                            if (r_push_open) begin
                                w_fin        = 1'b1;
                                w_res.status = lprr_pkg::ST_SEQ;
                            end else if (!w_room_ok) begin
                                w_fin        = 1'b1;
                                w_res.status = lprr_pkg::ST_ROOM;
                            end else begin
                                n_addr  = r_wp;
                                n_cnt   = '0;
                                n_state = S_HDRW;
                            end
                        end
                        lprr_pkg::CMD_PUSH_BYTE: begin
                            w_fin = 1'b1;
                            if (!r_push_open) begin
                                w_res.status = lprr_pkg::ST_SEQ;
                            end else begin
                                // Write the byte now; commit on the final one.
                                w_we      = 1'b1;
                                w_waddr   = r_pushc;
                                w_wdata   = i_in_data.data_in;
                                n_pushc   = f_adv(r_pushc);
                                n_pushrem = r_pushrem - 12'd1;
                                if (r_pushrem == 12'd1) begin
                                    n_wp        = f_adv(r_pushc);
                                    n_push_open = 1'b0;
                                    w_res.last  = 1'b1;
                                end
                            end
                        end
                        lprr_pkg::CMD_POP_START: begin
                            if (r_pop_open) begin
                                w_fin        = 1'b1;
                                w_res.status = lprr_pkg::ST_SEQ;
                            end else if (r_rp == r_wp) begin
                                w_fin        = 1'b1;
                                w_res.status = lprr_pkg::ST_EMPTY;
                            end else begin
                                n_addr  = r_rp;
                                n_cnt   = '0;
                                n_state = S_HDRR;
                            end
                        end
                        default: begin
                            if (!r_pop_open) begin
                                w_fin        = 1'b1;
                                w_res.status = lprr_pkg::ST_SEQ;
                            end else begin
                                // Read issued at r_popc this cycle; data next cycle.
                                w_raddr  = r_popc;
                                n_popc   = f_adv(r_popc);
                                n_poprem = r_poprem - 12'd1;
                                n_plast  = (r_poprem == 12'd1);
                                if (r_poprem == 12'd1) begin
                                    n_rp       = f_adv(r_popc);
                                    n_pop_open = 1'b0;
                                end
                                n_state = S_PBYTE;
                            end
                        end
                    endcase
                end
            end
            S_HDRW: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = w_hdr_wr[r_cnt[HIW-1:0]];
                n_addr  = f_adv(r_addr);
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CW'(HB - 1)) begin
                    w_fin     = 1'b1;
                    n_pushc   = f_adv(r_addr);
                    n_pushrem = r_len;
                    if (r_len == 12'd0) begin
                        n_wp       = f_adv(r_addr);
                        w_res.last = 1'b1;
                    end else begin
                        n_push_open = 1'b1;
                    end
                end
            end
            S_HDRR: begin
                w_raddr = r_addr;
                if (r_cnt != CW'(HB)) begin
                    n_addr = f_adv(r_addr);
                    n_cnt  = r_cnt + CW'(1);
                    if (r_cnt != '0) begin
                        n_hdr = w_hdr_rd;
                    end
                end else begin
                    // All header bytes in; r_addr already points past the header.
                    w_fin               = 1'b1;
                    w_res.record_length = w_payload[11:0];
                    w_res.flow_out      = w_hdr_rd[63:32];
                    if (w_payload > 32'(r_len)) begin
                        w_res.status = lprr_pkg::ST_TOOBIG;
                    end else begin
                        n_popc   = r_addr;
                        n_poprem = w_payload[11:0];
                        if (w_payload == 32'd0) begin
                            n_rp       = r_addr;
                            w_res.last = 1'b1;
                        end else begin
                            n_pop_open = 1'b1;
                        end
                    end
                end
            end
            S_PBYTE: begin
                w_fin          = 1'b1;
                w_res.data_out = w_rdata;
                w_res.last     = r_plast;
            end
            S_HOLD: begin
                w_fin = 1'b1;
                w_res = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it if that is full.
        if (w_fin) begin
            if (w_out_free) begin
                n_out    = w_res;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end else begin
                n_res   = w_res;
                n_state = S_HOLD;
            end
        end else if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_pushc     <= '0;
            r_pushrem   <= '0;
            r_popc      <= '0;
            r_poprem    <= '0;
            r_push_open <= 1'b0;
            r_pop_open  <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_pushc     <= n_pushc;
            r_pushrem   <= n_pushrem;
            r_popc      <= n_popc;
            r_poprem    <= n_poprem;
            r_push_open <= n_push_open;
            r_pop_open  <= n_pop_open;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_len   <= n_len;
        r_flow  <= n_flow;
        r_hdr   <= n_hdr;
        r_plast <= n_plast;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Header writes only start when no push is open.
    a_hdrw_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDRW) |-> !r_push_open)
        else $error("header write with push open");

    // An open push or pop always has bytes left to move.
    a_push_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_push_open |-> (r_pushrem != 12'd0))
        else $error("open push with nothing left");

    a_pop_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pop_open |-> (r_poprem != 12'd0))
        else $error("open pop with nothing left");

    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((PW+1)'(r_rp) < (PW+1)'(RING_BYTES)) && ((PW+1)'(r_wp) < (PW+1)'(RING_BYTES)))
        else $error("pointer past ring end");

    // A parked result goes out as soon as the output register frees up.
    a_hold_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && i_out_ready) |=> (r_state == S_IDLE) && o_out_valid)
        else $error("held result not delivered");

endmodule
